FILE: rtl/pre_pkg.sv
// Shared types and constants of the page replacement engine.
`timescale 1ns / 1ps

package pre_pkg;

   localparam int MAX_FRAMES   = 16;
   localparam int PAGE_BITS    = 20;
   localparam int USE_BITS     = 32;
   localparam int TOTAL_BITS   = 32;
   localparam int CFG_BITS     = 5;
   localparam int CSR_IDX_BITS = 1;
   localparam int FIDX_BITS    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_BITS     = $clog2(MAX_FRAMES + 1);

   typedef enum logic [1:0] {
      POL_FIFO = 2'd0,
      POL_LRU  = 2'd1,
      POL_LFU  = 2'd2,
      POL_MFU  = 2'd3
   } policy_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_POLICY = 1'b0,
      CSR_FRAMES = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_COMMIT = 2'd3
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 read;
      logic [FIDX_BITS-1:0] rd_addr;
      logic                 commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [FIDX_BITS-1:0] last_idx;
      logic                 out_free;
   } dp_status_type;

endpackage

FILE: rtl/pre_ctrl.sv
// Controller state machine that sequences the frame scan and the commit.
`timescale 1ns / 1ps

module pre_ctrl import pre_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type            state_ff, state_in;
   logic [FIDX_BITS-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.read    = 1'b0;
      cmd.rd_addr = idx_ff;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == status.last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/pre_datapath.sv
// Datapath: frame store, scan evaluation, victim choice, totals and result register.
`timescale 1ns / 1ps

module pre_datapath import pre_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   input  logic [PAGE_BITS-1:0]    req_page_number,
   input  logic                    req_is_write,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic [FIDX_BITS-1:0]    rsp_frame_index,
   output logic                    rsp_evicted,
   output logic [PAGE_BITS-1:0]    rsp_evicted_page,
   output logic                    rsp_write_back,
   output logic [TOTAL_BITS-1:0]   rsp_hit_total,
   output logic [TOTAL_BITS-1:0]   rsp_read_total,
   output logic [TOTAL_BITS-1:0]   rsp_write_total
);

   function automatic logic [TOTAL_BITS-1:0] sat_inc(input logic [TOTAL_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Frame store
   logic [PAGE_BITS-1:0] tag_mem [MAX_FRAMES];
   logic [USE_BITS-1:0]  use_mem [MAX_FRAMES];

   // Control state
   policy_type            policy_ff, policy_in;
   logic [CFG_BITS-1:0]   frames_ff, frames_in;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [MAX_FRAMES-1:0] dirty_ff, dirty_in;
   logic [FIDX_BITS-1:0]  rr_ff, rr_in;
   logic [USE_BITS-1:0]   seq_ff, seq_in;
   logic [TOTAL_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_BITS-1:0] read_cnt_ff, read_cnt_in;
   logic [TOTAL_BITS-1:0] write_cnt_ff, write_cnt_in;
   logic                  eval_en_ff, eval_en_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Item and scan registers
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic                  wr_ff, wr_in;
   logic [FIDX_BITS-1:0]  last_ff, last_in;
   logic [FIDX_BITS-1:0]  rr_vic_ff, rr_vic_in;
   logic [FIDX_BITS-1:0]  eval_idx_ff, eval_idx_in;
   logic [PAGE_BITS-1:0]  tag_rd_ff;
   logic [USE_BITS-1:0]   use_rd_ff;
   logic                  hit_found_ff, hit_found_in;
   logic [FIDX_BITS-1:0]  hit_idx_ff, hit_idx_in;
   logic [USE_BITS-1:0]   hit_use_ff, hit_use_in;
   logic                  empty_found_ff, empty_found_in;
   logic [FIDX_BITS-1:0]  empty_idx_ff, empty_idx_in;
   logic [FIDX_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [USE_BITS-1:0]   best_use_ff, best_use_in;
   logic [PAGE_BITS-1:0]  best_tag_ff, best_tag_in;

   // Result register
   logic                  o_hit_ff, o_hit_in;
   logic [FIDX_BITS-1:0]  o_idx_ff, o_idx_in;
   logic                  o_evicted_ff, o_evicted_in;
   logic [PAGE_BITS-1:0]  o_evpage_ff, o_evpage_in;
   logic                  o_wb_ff, o_wb_in;

   // Combinational helpers
   logic [CNT_BITS-1:0]   n_act;
   logic                  match;
   logic                  take;
   logic [FIDX_BITS-1:0]  slot;
   logic                  evict;
   logic                  wb;
   logic [USE_BITS-1:0]   use_new;
   logic [CNT_BITS-1:0]   rr_next;

   // A frame count of zero acts as one, and one above the store acts as the full store.
   always_comb begin
      if (frames_ff == '0) begin
         n_act = CNT_BITS'(1);
      end else if (frames_ff > CFG_BITS'(MAX_FRAMES)) begin
         n_act = CNT_BITS'(MAX_FRAMES);
      end else begin
         n_act = CNT_BITS'(frames_ff);
      end
   end

   // The last index is kept with the item for the scan bound of the controller.
   assign status.last_idx = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Scan evaluation on the registered read of the frame at eval_idx_ff.
   assign match = valid_ff[eval_idx_ff] && (tag_rd_ff == page_ff);

   always_comb begin
      case (policy_ff)
         POL_FIFO: take = (eval_idx_ff == rr_vic_ff);
         POL_MFU:  take = (eval_idx_ff == '0) || (use_rd_ff > best_use_ff);
         default:  take = (eval_idx_ff == '0) || (use_rd_ff < best_use_ff);
      endcase
   end

   // Commit decisions
   assign evict = !hit_found_ff && !empty_found_ff;
   assign wb    = evict && dirty_ff[best_idx_ff];
   assign slot  = hit_found_ff ? hit_idx_ff : (empty_found_ff ? empty_idx_ff : best_idx_ff);
   assign rr_next = CNT_BITS'(best_idx_ff) + 1'b1;

   always_comb begin
      case (policy_ff) inside
         POL_LRU: use_new = seq_ff;
         POL_LFU, POL_MFU: begin
            if (hit_found_ff) begin
               use_new = (&hit_use_ff) ? hit_use_ff : hit_use_ff + 1'b1;
            end else begin
               use_new = USE_BITS'(1);
            end
         end
         default: use_new = hit_found_ff ? hit_use_ff : '0;
      endcase
   end

   always_comb begin
      policy_in      = policy_ff;
      frames_in      = frames_ff;
      valid_in       = valid_ff;
      dirty_in       = dirty_ff;
      rr_in          = rr_ff;
      seq_in         = seq_ff;
      hit_cnt_in     = hit_cnt_ff;
      read_cnt_in    = read_cnt_ff;
      write_cnt_in   = write_cnt_ff;
      eval_en_in     = cmd.read;
      eval_idx_in    = cmd.rd_addr;
      rsp_valid_in   = rsp_valid_ff;
      page_in        = page_ff;
      wr_in          = wr_ff;
      last_in        = last_ff;
      rr_vic_in      = rr_vic_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_use_in     = hit_use_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      best_idx_in    = best_idx_ff;
      best_use_in    = best_use_ff;
      best_tag_in    = best_tag_ff;
      o_hit_in       = o_hit_ff;
      o_idx_in       = o_idx_ff;
      o_evicted_in   = o_evicted_ff;
      o_evpage_in    = o_evpage_ff;
      o_wb_in        = o_wb_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY: policy_in = policy_type'(csr_wdata[1:0]);
            CSR_FRAMES: frames_in = csr_wdata;
            default:    ;
         endcase
      end

      if (cmd.load) begin
         page_in        = req_page_number;
         wr_in          = req_is_write;
         last_in        = FIDX_BITS'(n_act - 1'b1);
         rr_vic_in      = (CNT_BITS'(rr_ff) < n_act) ? rr_ff : '0;
         hit_found_in   = 1'b0;
         empty_found_in = 1'b0;
         best_idx_in    = '0;
      end

      if (eval_en_ff) begin
         if (match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = eval_idx_ff;
            hit_use_in   = use_rd_ff;
         end
         if (!valid_ff[eval_idx_ff] && !empty_found_ff) begin
            empty_found_in = 1'b1;
            empty_idx_in   = eval_idx_ff;
         end
         if (take) begin
            best_idx_in = eval_idx_ff;
            best_use_in = use_rd_ff;
            best_tag_in = tag_rd_ff;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         o_hit_in       = hit_found_ff;
         o_idx_in       = slot;
         o_evicted_in   = evict;
         o_evpage_in    = evict ? best_tag_ff : '0;
         o_wb_in        = wb;
         valid_in[slot] = 1'b1;
         dirty_in[slot] = hit_found_ff ? (dirty_ff[slot] | wr_ff) : wr_ff;
         seq_in         = seq_ff + 1'b1;
         if (hit_found_ff) begin
            hit_cnt_in = sat_inc(hit_cnt_ff);
         end else begin
            read_cnt_in = sat_inc(read_cnt_ff);
         end
         if (wb) begin
            write_cnt_in = sat_inc(write_cnt_ff);
         end
         if (evict && (policy_ff == POL_FIFO)) begin
            rr_in = (rr_next >= n_act) ? '0 : FIDX_BITS'(rr_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_FIFO;
         frames_ff    <= CFG_BITS'(MAX_FRAMES);
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rr_ff        <= '0;
         seq_ff       <= USE_BITS'(1);
         hit_cnt_ff   <= '0;
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
         eval_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rr_ff        <= rr_in;
         seq_ff       <= seq_in;
         hit_cnt_ff   <= hit_cnt_in;
         read_cnt_ff  <= read_cnt_in;
         write_cnt_ff <= write_cnt_in;
         eval_en_ff   <= eval_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      wr_ff          <= wr_in;
      last_ff        <= last_in;
      rr_vic_ff      <= rr_vic_in;
      eval_idx_ff    <= eval_idx_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_use_ff     <= hit_use_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      best_idx_ff    <= best_idx_in;
      best_use_ff    <= best_use_in;
      best_tag_ff    <= best_tag_in;
      o_hit_ff       <= o_hit_in;
      o_idx_ff       <= o_idx_in;
      o_evicted_ff   <= o_evicted_in;
      o_evpage_ff    <= o_evpage_in;
      o_wb_ff        <= o_wb_in;
   end

   // Frame store: one read port for the scan, one write port for the commit.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         tag_rd_ff <= tag_mem[cmd.rd_addr];
         use_rd_ff <= use_mem[cmd.rd_addr];
      end
      if (cmd.commit) begin
         tag_mem[slot] <= page_ff;
         use_mem[slot] <= use_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = o_hit_ff;
   assign rsp_frame_index  = o_idx_ff;
   assign rsp_evicted      = o_evicted_ff;
   assign rsp_evicted_page = o_evpage_ff;
   assign rsp_write_back   = o_wb_ff;
   // Totals change only at a commit, which waits for the result register to free up.
   assign rsp_hit_total    = hit_cnt_ff;
   assign rsp_read_total   = read_cnt_ff;
   assign rsp_write_total  = write_cnt_ff;

endmodule

FILE: rtl/page_replacement_engine.sv
// Top level of the page replacement engine: controller plus datapath.
// An accepted item is scanned over the n active frames (1 to 16), one frame a cycle,
// and its result is loaded into the result register at the commit. A new item is
// accepted only after the previous one has committed.
// Reset (synchronous, active high) empties all frames, clears the totals, drops any held
// result, sets the policy to FIFO, the frame count to 16 and the access sequence to one.
`timescale 1ns / 1ps

module page_replacement_engine import pre_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // Configuration writes
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   // Page access items
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PAGE_BITS-1:0]    req_page_number,
   input  logic                    req_is_write,
   // Result items
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic [FIDX_BITS-1:0]    rsp_frame_index,
   output logic                    rsp_evicted,
   output logic [PAGE_BITS-1:0]    rsp_evicted_page,
   output logic                    rsp_write_back,
   output logic [TOTAL_BITS-1:0]   rsp_hit_total,
   output logic [TOTAL_BITS-1:0]   rsp_read_total,
   output logic [TOTAL_BITS-1:0]   rsp_write_total
);

   // The controller walks the active frames one per cycle. The datapath registers each
   // frame's tag and use value, then in the following cycle checks for the first tag
   // match, the first empty frame and the victim candidate (round-robin frame under FIFO,
   // first smallest use value under LRU and LFU, first largest under MFU).
   // After the last frame is evaluated, the commit updates the frame store and the totals
   // and loads the result register. The commit waits while an earlier result is still
   // held, so a new item can be accepted and scanned while the previous result waits.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   pre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pre_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_page_number  (req_page_number),
      .req_is_write     (req_is_write),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_write_back   (rsp_write_back),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_read_total   (rsp_read_total),
      .rsp_write_total  (rsp_write_total)
   );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the page replacement engine, with stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb_top;
   import pre_pkg::*;

   // The run is stopped here if the results stop arriving.
   localparam int CYCLE_LIMIT = 200000;
   // Cycles waited after draining, so that a stray result can still show up.
   localparam int SETTLE_CYCLES = 40;
   // The receiver holds off for this many cycles once, so that the engine backs up.
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SEGMENTS = 12;
   localparam int ACCESSES_PER_SEGMENT = 62;

   typedef struct {
      logic [PAGE_BITS-1:0] page;
      logic                 is_write;
   } page_access_type;

   typedef struct {
      logic                  hit;
      logic [FIDX_BITS-1:0]  frame_index;
      logic                  evicted;
      logic [PAGE_BITS-1:0]  evicted_page;
      logic                  write_back;
      logic [TOTAL_BITS-1:0] hit_total;
      logic [TOTAL_BITS-1:0] read_total;
      logic [TOTAL_BITS-1:0] write_total;
   } access_outcome_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_POLICY;
   logic [CFG_BITS-1:0]     csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PAGE_BITS-1:0]    req_page_number = '0;
   logic                    req_is_write = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_hit;
   logic [FIDX_BITS-1:0]    rsp_frame_index;
   logic                    rsp_evicted;
   logic [PAGE_BITS-1:0]    rsp_evicted_page;
   logic                    rsp_write_back;
   logic [TOTAL_BITS-1:0]   rsp_hit_total;
   logic [TOTAL_BITS-1:0]   rsp_read_total;
   logic [TOTAL_BITS-1:0]   rsp_write_total;

   page_replacement_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page_number  (req_page_number),
      .req_is_write     (req_is_write),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_write_back   (rsp_write_back),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_read_total   (rsp_read_total),
      .rsp_write_total  (rsp_write_total)
   );

   // Accesses waiting to be offered, and the outcomes predicted for accesses already taken.
   page_access_type    pending_accesses[$];
   access_outcome_type predicted_outcomes[$];

   // Idle rates in percent, set per segment by the stimulus process.
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit allow_long_hold = 1'b0;

   int error_count = 0;
   int cycle_count = 0;

   // Shadow copy of the engine's configuration and frame table.
   policy_type            shadow_policy = POL_FIFO;
   logic [CFG_BITS-1:0]   shadow_frames = 5'd16;
   logic [PAGE_BITS-1:0]  shadow_tag [MAX_FRAMES];
   bit                    shadow_valid [MAX_FRAMES];
   bit                    shadow_dirty [MAX_FRAMES];
   logic [USE_BITS-1:0]   shadow_use [MAX_FRAMES];
   logic [USE_BITS-1:0]   shadow_sequence = 1;
   logic [FIDX_BITS-1:0]  shadow_rr_next = '0;
   logic [TOTAL_BITS-1:0] shadow_hits = '0;
   logic [TOTAL_BITS-1:0] shadow_reads = '0;
   logic [TOTAL_BITS-1:0] shadow_writes = '0;

   initial begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         shadow_tag[k] = '0;
         shadow_valid[k] = 1'b0;
         shadow_dirty[k] = 1'b0;
         shadow_use[k] = '0;
      end
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [TOTAL_BITS-1:0] bump_total(input logic [TOTAL_BITS-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   // Works out the outcome of one access and updates the shadow frame table the way the
   // engine must: hit search, then an empty frame, then a victim chosen by the policy.
   function automatic access_outcome_type predict_access(input logic [PAGE_BITS-1:0] page,
                                                         input logic is_write);
      access_outcome_type outcome;
      int active;
      int slot;
      bit found;
      active = shadow_frames;
      if (active < 1) active = 1;
      if (active > MAX_FRAMES) active = MAX_FRAMES;
      outcome = '{default: '0};
      slot = 0;
      found = 1'b0;

      // The lowest matching frame wins, which matters once duplicate tags exist.
      for (int k = 0; k < active; k++) begin
         if (!found && shadow_valid[k] && shadow_tag[k] == page) begin
            found = 1'b1;
            slot = k;
         end
      end

      if (found) begin
         outcome.hit = 1'b1;
         shadow_hits = bump_total(shadow_hits);
         if (is_write) shadow_dirty[slot] = 1'b1;
         if (shadow_policy == POL_LRU) begin
            shadow_use[slot] = shadow_sequence;
         end else if (shadow_policy == POL_LFU || shadow_policy == POL_MFU) begin
            if (shadow_use[slot] != '1) shadow_use[slot] = shadow_use[slot] + 1'b1;
         end
      end else begin
         shadow_reads = bump_total(shadow_reads);
         for (int k = 0; k < active; k++) begin
            if (!found && !shadow_valid[k]) begin
               found = 1'b1;
               slot = k;
            end
         end
         if (!found) begin
            if (shadow_policy == POL_FIFO) begin
               // A pointer left beyond the active frames by a smaller frame count starts over.
               slot = (shadow_rr_next < active) ? int'(shadow_rr_next) : 0;
               shadow_rr_next = (slot + 1 >= active) ? '0 : FIDX_BITS'(slot + 1);
            end else begin
               slot = 0;
               for (int k = 1; k < active; k++) begin
                  if (shadow_policy == POL_MFU) begin
                     if (shadow_use[k] > shadow_use[slot]) slot = k;
                  end else begin
                     if (shadow_use[k] < shadow_use[slot]) slot = k;
                  end
               end
            end
            outcome.evicted = 1'b1;
            outcome.evicted_page = shadow_tag[slot];
            if (shadow_dirty[slot]) begin
               outcome.write_back = 1'b1;
               shadow_writes = bump_total(shadow_writes);
            end
         end
         shadow_tag[slot] = page;
         shadow_valid[slot] = 1'b1;
         shadow_dirty[slot] = is_write;
         case (shadow_policy) inside
            POL_LRU: shadow_use[slot] = shadow_sequence;
            POL_LFU, POL_MFU: shadow_use[slot] = 1;
            default: shadow_use[slot] = '0;
         endcase
      end

      shadow_sequence = shadow_sequence + 1'b1;
      outcome.frame_index = FIDX_BITS'(slot);
      outcome.hit_total = shadow_hits;
      outcome.read_total = shadow_reads;
      outcome.write_total = shadow_writes;
      return outcome;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Sender side. An access that is taken at this edge is predicted right away, since the
   // shadow state must move in the same order as the engine's.
   always @(posedge clock) begin : access_driver
      bit slot_free;
      page_access_type next_access;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         slot_free = !req_valid || req_ready;
         if (req_valid && req_ready) begin
            predicted_outcomes.push_back(predict_access(req_page_number, req_is_write));
         end
         if (slot_free) begin
            if (pending_accesses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_access = pending_accesses.pop_front();
               req_valid <= 1'b1;
               req_page_number <= next_access.page;
               req_is_write <= next_access.is_write;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver side. Each result taken is compared field by field with the oldest prediction.
   // Once, during the segments without idling, the receiver holds off for a long stretch
   // while the sender keeps offering, so that the engine backs up and stops taking accesses.
   int ready_hold_left = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin : result_monitor
      access_outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outcomes.size() == 0) begin
               $error("result item arrived with no access outstanding");
               error_count++;
            end else begin
               want = predicted_outcomes.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("frame_index", 32'(want.frame_index), 32'(rsp_frame_index));
               check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
               check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_evicted_page));
               check_field("write_back", 32'(want.write_back), 32'(rsp_write_back));
               check_field("hit_total", want.hit_total, rsp_hit_total);
               check_field("read_total", want.read_total, rsp_read_total);
               check_field("write_total", want.write_total, rsp_write_total);
            end
         end
         if (ready_hold_left != 0) begin
            ready_hold_left--;
            rsp_ready <= 1'b0;
         end else if (allow_long_hold && !long_hold_done && rsp_valid) begin
            ready_hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The engine is idle once nothing is queued, nothing is offered and every predicted
   // result has come back. Every access gives exactly one result, so nothing lingers after.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_valid || predicted_outcomes.size() != 0);
   endtask

   // Register writes only happen on a drained engine, so the shadow copy can follow at once.
   task automatic write_register(input csr_index_type index, input logic [CFG_BITS-1:0] value);
      wait_until_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_POLICY) shadow_policy = policy_type'(value[1:0]);
      else shadow_frames = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_access(input logic [PAGE_BITS-1:0] page, input logic is_write);
      pending_accesses.push_back('{page: page, is_write: is_write});
   endtask

   initial begin : stimulus
      logic [PAGE_BITS-1:0] page_pool[$];
      policy_type seg_policy;
      logic [CFG_BITS-1:0] seg_frames;
      int active;
      int pick;

      sender_idle_pct = 14;
      receiver_idle_pct = 73;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Two FIFO frames: fills, a write hit, and evictions of dirty pages
      // at both ends of the page range.
      write_register(CSR_FRAMES, 5'd2);
      queue_access('0, 1'b0);
      queue_access('1, 1'b1);
      queue_access('0, 1'b1);
      queue_access(20'd5, 1'b0);
      queue_access('1, 1'b0);
      queue_access(20'd6, 1'b1);
      // Switching policy with the use values left as FIFO wrote them.
      write_register(CSR_POLICY, POL_LRU);
      queue_access(20'd5, 1'b0);
      queue_access(20'd7, 1'b0);
      write_register(CSR_POLICY, POL_LFU);
      queue_access(20'd7, 1'b1);
      queue_access(20'd8, 1'b0);
      write_register(CSR_POLICY, POL_MFU);
      queue_access(20'd9, 1'b0);
      // A zero frame count acts as one frame. Loading the page held by frame 1 into frame 0
      // leaves a duplicate tag once the count grows again.
      write_register(CSR_FRAMES, 5'd0);
      queue_access(20'd8, 1'b0);
      queue_access(20'd9, 1'b1);
      // A count above the maximum acts as the maximum; the lowest duplicate must hit.
      write_register(CSR_FRAMES, 5'd31);
      queue_access(20'd8, 1'b0);
      queue_access(20'd9, 1'b0);
      queue_access(20'habcde, 1'b1);
      // FIFO over three frames moves the pointer to the last frame; shrinking to two
      // frames then leaves it out of range, so the next victim is frame 0.
      write_register(CSR_POLICY, POL_FIFO);
      write_register(CSR_FRAMES, 5'd3);
      queue_access(20'h12345, 1'b0);
      queue_access(20'h54321, 1'b1);
      write_register(CSR_FRAMES, 5'd2);
      queue_access(20'h0f0f0, 1'b0);

      // Random part. Each segment drains the engine, then sets a new policy and frame count.
      // Most accesses come from a small pool of pages so that hits and evictions both occur.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 4) begin
            sender_idle_pct = 14;
            receiver_idle_pct = 73;
         end else if (seg < 8) begin
            sender_idle_pct = 73;
            receiver_idle_pct = 14;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         seg_policy = policy_type'((seg + seg / 4) % 4);
         case (seg)
            0, 3, 4: seg_frames = 5'd16;
            1:       seg_frames = 5'd1;
            2:       seg_frames = 5'd4;
            5:       seg_frames = 5'd9;
            6:       seg_frames = 5'd31;
            7:       seg_frames = 5'd2;
            8:       seg_frames = 5'd0;
            9:       seg_frames = 5'd3;
            10:      seg_frames = 5'd17;
            default: seg_frames = 5'd12;
         endcase
         // The upper bits of a policy write are ignored, so they get random values.
         write_register(CSR_POLICY, {3'($urandom_range(7)), seg_policy});
         write_register(CSR_FRAMES, seg_frames);
         if (seg == 8) allow_long_hold = 1'b1;

         active = seg_frames;
         if (active < 1) active = 1;
         if (active > MAX_FRAMES) active = MAX_FRAMES;
         page_pool.delete();
         repeat ($urandom_range(2 * active + 3, 1)) begin
            pick = $urandom_range(9);
            if (pick == 0) page_pool.push_back('0);
            else if (pick == 1) page_pool.push_back('1);
            else page_pool.push_back(PAGE_BITS'($urandom));
         end
         repeat (ACCESSES_PER_SEGMENT) begin
            if ($urandom_range(99) < 85)
               queue_access(page_pool[$urandom_range(page_pool.size() - 1)],
                            1'($urandom_range(1)));
            else
               queue_access(PAGE_BITS'($urandom), 1'($urandom_range(1)));
         end
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
